[hw/rtl/ahsh_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register indexes and constants of the altitude/heading/speed hold unit.
package ahsh_pkg;

  localparam int SETPOINT_FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] REG_ALT_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDG_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIMB_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_BITS  = 3'd6;

  localparam int MODE_DAMPING  = 0;
  localparam int MODE_AUTO_THR = 2;

  typedef struct packed {
    logic [23:0] altitude_start;
    logic [15:0] heading_start;
    logic [23:0] speed_start;
    logic [24:0] climb_rate;
    logic [17:0] turn_rate;
    logic [24:0] accel_rate;
    logic [2:0]  mode_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    altitude_start: 24'd16000,
    heading_start:  16'd16384,
    speed_start:    24'd3200,
    climb_rate:     25'd0,
    turn_rate:      18'd0,
    accel_rate:     25'd0,
    mode_bits:      3'd7
  };

  // altitude and speed range, 1/16 units
  localparam logic [23:0] SP_RANGE_MAX = 24'd16000000;

  // throttle: full at no overspeed, zero at 80/16 m/s (5 m/s) overspeed
  localparam logic [15:0] THR_FULL     = 16'hFFFF;
  localparam int          THR_SPAN     = 80;
  localparam logic [19:0] THR_RECIP    = 20'd838861;   // ceil(2^22 / 5)
  localparam int          THR_RECIP_SH = 22;

  // pitch: altitude error clamped to 500 m, full scale 10 degrees
  localparam int          PITCH_CLAMP    = 8000;
  localparam int          PITCH_HALF_DEN = 1125;
  localparam logic [20:0] PITCH_RECIP    = 21'd1908875; // ceil(2^31 / 1125)
  localparam int          PITCH_RECIP_SH = 31;

  // bank: +-45 degrees
  localparam int BANK_LIMIT = 8192;

endpackage

[hw/rtl/ahsh_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file of the altitude/heading/speed hold unit.
module ahsh_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ahsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ahsh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ahsh_pkg::cfg_t                 cfg
);
  import ahsh_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ALT_START:  cfg_nxt.altitude_start = cfg_wdata[23:0];
        REG_HDG_START:  cfg_nxt.heading_start  = cfg_wdata[15:0];
        REG_SPD_START:  cfg_nxt.speed_start    = cfg_wdata[23:0];
        REG_CLIMB_RATE: cfg_nxt.climb_rate     = cfg_wdata[24:0];
        REG_TURN_RATE:  cfg_nxt.turn_rate      = cfg_wdata[17:0];
        REG_ACCEL_RATE: cfg_nxt.accel_rate     = cfg_wdata[24:0];
        REG_MODE_BITS:  cfg_nxt.mode_bits      = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/ahsh_setpoint.sv]
`timescale 1ns / 1ps
// Input register, rate-times-step products and setpoint integration.
module ahsh_setpoint #(
  parameter int FRAC_BITS = ahsh_pkg::SETPOINT_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ahsh_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [15:0]              in_time_step,
  input  logic [23:0]              in_airspeed,
  input  logic [23:0]              in_altitude_now,
  input  logic [15:0]              in_heading_now,
  input  logic                     in_restart,
  output logic                     sp_valid,
  input  logic                     sp_ready,
  output logic [23:0]              sp_airspeed,
  output logic [23:0]              sp_altitude_now,
  output logic [15:0]              sp_heading_now,
  output logic [24+FRAC_BITS-1:0]  sp_alt,
  output logic [24+FRAC_BITS-1:0]  sp_spd,
  output logic [16+FRAC_BITS-1:0]  sp_hdg
);
  import ahsh_pkg::*;

  localparam int SPW  = 24 + FRAC_BITS;
  localparam int HW   = 16 + FRAC_BITS;
  localparam int LIFT = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DROP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int AW   = 42 + LIFT;  // altitude/speed step
  localparam int TW   = 35 + LIFT;  // heading step
  localparam int SUMW = ((SPW + 1 > AW) ? SPW + 1 : AW) + 1;
  localparam logic [SPW-1:0] SP_MAX = SPW'(SP_RANGE_MAX) << FRAC_BITS;

  function automatic logic [SPW-1:0] sat_sp(input logic signed [SUMW-1:0] v);
    logic [SPW-1:0] res;
    if (v[SUMW-1]) begin
      res = '0;
    end else if (v[SUMW-2:0] > (SUMW-1)'(SP_MAX)) begin
      res = SP_MAX;
    end else begin
      res = v[SPW-1:0];
    end
    return res;
  endfunction

  // pipeline control
  logic v1_r, v2_r, v3_r;
  logic ready1, ready2, ready3;
  logic ld1, ld2, ld3;

  assign ready3   = !v3_r || sp_ready;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;
  assign ld1      = in_valid && ready1;
  assign ld2      = v1_r && ready2;
  assign ld3      = v2_r && ready3;

  // stage 1: input register
  logic [15:0] dt1_r;
  logic [23:0] air1_r, alt1_r;
  logic [15:0] hdg1_r;
  logic        rst1_r;

  // stage 2: scaled setpoint steps
  logic signed [41:0]   alt_prod, spd_prod;
  logic signed [34:0]   hdg_prod;
  logic signed [16:0]   dt_s;
  logic signed [AW-1:0] alt_wide, spd_wide;
  logic signed [TW-1:0] hdg_wide;
  logic signed [AW-1:0] alt_step_nxt, spd_step_nxt;
  logic signed [TW-1:0] hdg_step_nxt;

  logic signed [AW-1:0] alt_step2_r, spd_step2_r;
  logic signed [TW-1:0] hdg_step2_r;
  logic [23:0]          air2_r, alt2_r;
  logic [15:0]          hdg2_r;
  logic                 rst2_r;

  assign dt_s     = $signed({1'b0, dt1_r});
  assign alt_prod = 42'($signed(cfg.climb_rate)) * 42'(dt_s);
  assign spd_prod = 42'($signed(cfg.accel_rate)) * 42'(dt_s);
  assign hdg_prod = 35'($signed(cfg.turn_rate)) * 35'(dt_s);
  assign alt_wide = AW'(alt_prod);
  assign spd_wide = AW'(spd_prod);
  assign hdg_wide = TW'(hdg_prod);
  // product has 16 fraction bits; move to FRAC_BITS, floor on drop
  assign alt_step_nxt = (alt_wide <<< LIFT) >>> DROP;
  assign spd_step_nxt = (spd_wide <<< LIFT) >>> DROP;
  assign hdg_step_nxt = (hdg_wide <<< LIFT) >>> DROP;

  // stage 3: setpoint state
  logic [SPW-1:0]         alt_sp_r, spd_sp_r;
  logic [HW-1:0]          hdg_sp_r;
  logic [SPW-1:0]         alt_base, spd_base;
  logic [HW-1:0]          hdg_base;
  logic signed [SUMW-1:0] alt_sum, spd_sum;
  logic [SPW-1:0]         alt_sp_nxt, spd_sp_nxt;
  logic [HW-1:0]          hdg_sp_nxt;
  logic [23:0]            air3_r, alt3_r;
  logic [15:0]            hdg3_r;

  assign alt_base = rst2_r ? (SPW'(cfg.altitude_start) << FRAC_BITS) : alt_sp_r;
  assign spd_base = rst2_r ? (SPW'(cfg.speed_start) << FRAC_BITS) : spd_sp_r;
  assign hdg_base = rst2_r ? (HW'(cfg.heading_start) << FRAC_BITS) : hdg_sp_r;

  assign alt_sum    = SUMW'($signed({1'b0, alt_base})) + SUMW'(alt_step2_r);
  assign spd_sum    = SUMW'($signed({1'b0, spd_base})) + SUMW'(spd_step2_r);
  assign alt_sp_nxt = sat_sp(alt_sum);
  assign spd_sp_nxt = sat_sp(spd_sum);
  // heading wraps modulo one turn
  assign hdg_sp_nxt = hdg_base + hdg_step2_r[HW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      alt_sp_r <= SPW'(CFG_RESET.altitude_start) << FRAC_BITS;
      spd_sp_r <= SPW'(CFG_RESET.speed_start) << FRAC_BITS;
      hdg_sp_r <= HW'(CFG_RESET.heading_start) << FRAC_BITS;
    end else begin
      if (ready1) begin
        v1_r <= in_valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
      if (ld3) begin
        alt_sp_r <= alt_sp_nxt;
        spd_sp_r <= spd_sp_nxt;
        hdg_sp_r <= hdg_sp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      dt1_r  <= in_time_step;
      air1_r <= in_airspeed;
      alt1_r <= in_altitude_now;
      hdg1_r <= in_heading_now;
      rst1_r <= in_restart;
    end
    if (ld2) begin
      alt_step2_r <= alt_step_nxt;
      spd_step2_r <= spd_step_nxt;
      hdg_step2_r <= hdg_step_nxt;
      air2_r      <= air1_r;
      alt2_r      <= alt1_r;
      hdg2_r      <= hdg1_r;
      rst2_r      <= rst1_r;
    end
    if (ld3) begin
      air3_r <= air2_r;
      alt3_r <= alt2_r;
      hdg3_r <= hdg2_r;
    end
  end

  // setpoint state stays put until the next item enters stage 3
  assign sp_valid        = v3_r;
  assign sp_airspeed     = air3_r;
  assign sp_altitude_now = alt3_r;
  assign sp_heading_now  = hdg3_r;
  assign sp_alt          = alt_sp_r;
  assign sp_spd          = spd_sp_r;
  assign sp_hdg          = hdg_sp_r;

endmodule

[hw/rtl/ahsh_target.sv]
`timescale 1ns / 1ps
// Error forming, clamping and constant scaling into throttle, pitch and bank targets.
module ahsh_target #(
  parameter int FRAC_BITS = ahsh_pkg::SETPOINT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [2:0]              mode_bits,
  input  logic                    sp_valid,
  output logic                    sp_ready,
  input  logic [23:0]             sp_airspeed,
  input  logic [23:0]             sp_altitude_now,
  input  logic [15:0]             sp_heading_now,
  input  logic [24+FRAC_BITS-1:0] sp_alt,
  input  logic [24+FRAC_BITS-1:0] sp_spd,
  input  logic [16+FRAC_BITS-1:0] sp_hdg,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [15:0]             out_throttle,
  output logic signed [11:0]      out_pitch_target,
  output logic signed [14:0]      out_bank_target,
  output logic                    out_damping_on
);
  import ahsh_pkg::*;

  localparam int SPW = 24 + FRAC_BITS;
  localparam int HW  = 16 + FRAC_BITS;
  localparam int EW  = FRAC_BITS + 7;   // overspeed below 80 << F
  localparam int TNW = FRAC_BITS + 24;
  localparam int DW  = FRAC_BITS + 13;  // altitude error below 8000 << F
  localparam int PNW = FRAC_BITS + 22;
  localparam int BNW = FRAC_BITS + 20;
  localparam logic [SPW-1:0] E_LIM = SPW'(THR_SPAN) << FRAC_BITS;
  localparam logic [SPW-1:0] D_LIM = SPW'(PITCH_CLAMP) << FRAC_BITS;

  // pipeline control
  logic v4_r, v5_r, vo_r;
  logic ready4, ready5, ready_o;
  logic ld4, ld5, ldo;

  assign ready_o  = !vo_r || !out_stall;
  assign ready5   = !v5_r || ready_o;
  assign ready4   = !v4_r || ready5;
  assign sp_ready = ready4;
  assign ld4      = sp_valid && ready4;
  assign ld5      = v4_r && ready5;
  assign ldo      = v5_r && ready_o;

  // stage 4: error magnitudes and signs
  logic [SPW-1:0] air_f, alt_f;
  logic [SPW:0]   e_diff, d_pos, d_neg;
  logic [HW-1:0]  hdg_f, h_pos, h_neg;
  logic           thr_full_nxt;
  logic [SPW-1:0] d_mag_nxt;
  logic [HW-1:0]  h_mag_nxt;

  assign air_f  = SPW'(sp_airspeed) << FRAC_BITS;
  assign alt_f  = SPW'(sp_altitude_now) << FRAC_BITS;
  assign hdg_f  = HW'(sp_heading_now) << FRAC_BITS;
  assign e_diff = {1'b0, air_f} - {1'b0, sp_spd};
  assign d_pos  = {1'b0, sp_alt} - {1'b0, alt_f};
  assign d_neg  = {1'b0, alt_f} - {1'b0, sp_alt};
  assign h_pos  = hdg_f - sp_hdg;
  assign h_neg  = sp_hdg - hdg_f;

  // no overspeed or manual throttle gives full thrust
  assign thr_full_nxt = !mode_bits[MODE_AUTO_THR] || e_diff[SPW] || (e_diff == '0);
  assign d_mag_nxt    = d_pos[SPW] ? d_neg[SPW-1:0] : d_pos[SPW-1:0];
  // half-turn error counts as negative; its magnitude still fits HW bits
  assign h_mag_nxt    = h_pos[HW-1] ? h_neg : h_pos;

  logic           thr_full4_r;
  logic [SPW-1:0] e4_r;
  logic           dneg4_r;
  logic [SPW-1:0] d4_r;
  logic           hneg4_r;
  logic [HW-1:0]  h4_r;

  // stage 5: clamps and rounding numerators
  logic           thr_zero_nxt;
  logic [TNW-1:0] te, tn;
  logic [DW-1:0]  dc;
  logic [PNW-1:0] pn;
  logic [BNW-1:0] bw, bn;

  assign thr_zero_nxt = e4_r >= E_LIM;
  assign te = TNW'(e4_r[EW-1:0]);
  // e * 131070 + 80 << F, then drop F+5 bits; the rest of /160 is /5
  assign tn = (te << 17) - (te << 1) + (TNW'(THR_SPAN) << FRAC_BITS);
  assign dc = (d4_r > D_LIM) ? D_LIM[DW-1:0] : d4_r[DW-1:0];
  // d * 512 + 1125 << F, then drop F+1 bits; the rest is /1125
  assign pn = (PNW'(dc) << 9) + (PNW'(PITCH_HALF_DEN) << FRAC_BITS);
  // (9h + 2^F) >> (F+1) rounds 9h / 2^(F+1)
  assign bw = BNW'(h4_r);
  assign bn = (bw << 3) + bw + (BNW'(1) << FRAC_BITS);

  logic        thr_full5_r, thr_zero5_r;
  logic [18:0] thr_m5_r;
  logic        pneg5_r;
  logic [20:0] pm5_r;
  logic        bneg5_r;
  logic [18:0] bm5_r;

  // output stage: reciprocal multiplies, clamp, sign
  logic [38:0] thr_prod;
  logic [16:0] thr_q;
  logic [15:0] thr_nxt;
  logic [41:0] p_prod;
  logic [11:0] p_mag, pitch_nxt;
  logic [13:0] b_clamp;
  logic [14:0] b_mag, bank_nxt;

  assign thr_prod = 39'(thr_m5_r) * 39'(THR_RECIP);
  assign thr_q    = thr_prod[38:THR_RECIP_SH];
  assign thr_nxt  = thr_full5_r ? THR_FULL :
                    thr_zero5_r ? 16'd0 : (THR_FULL - thr_q[15:0]);

  assign p_prod    = 42'(pm5_r) * 42'(PITCH_RECIP);
  assign p_mag     = {1'b0, p_prod[41:PITCH_RECIP_SH]};
  assign pitch_nxt = pneg5_r ? (12'd0 - p_mag) : p_mag;

  assign b_clamp  = (bm5_r > 19'(BANK_LIMIT)) ? 14'(BANK_LIMIT) : bm5_r[13:0];
  assign b_mag    = {1'b0, b_clamp};
  assign bank_nxt = bneg5_r ? (15'd0 - b_mag) : b_mag;

  logic [15:0] thr_r;
  logic [11:0] pitch_r;
  logic [14:0] bank_r;
  logic        damp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ready4) begin
        v4_r <= sp_valid;
      end
      if (ready5) begin
        v5_r <= v4_r;
      end
      if (ready_o) begin
        vo_r <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      thr_full4_r <= thr_full_nxt;
      e4_r        <= e_diff[SPW-1:0];
      dneg4_r     <= d_pos[SPW];
      d4_r        <= d_mag_nxt;
      hneg4_r     <= h_pos[HW-1];
      h4_r        <= h_mag_nxt;
    end
    if (ld5) begin
      thr_full5_r <= thr_full4_r;
      thr_zero5_r <= thr_zero_nxt;
      thr_m5_r    <= tn[TNW-1:FRAC_BITS+5];
      pneg5_r     <= dneg4_r;
      pm5_r       <= pn[PNW-1:FRAC_BITS+1];
      bneg5_r     <= hneg4_r;
      bm5_r       <= bn[BNW-1:FRAC_BITS+1];
    end
    if (ldo) begin
      thr_r   <= thr_nxt;
      pitch_r <= pitch_nxt;
      bank_r  <= bank_nxt;
      damp_r  <= mode_bits[MODE_DAMPING];
    end
  end

  assign out_valid        = vo_r;
  assign out_throttle     = thr_r;
  assign out_pitch_target = $signed(pitch_r);
  assign out_bank_target  = $signed(bank_r);
  assign out_damping_on   = damp_r;

endmodule

[hw/rtl/altitude_heading_speed_hold_unit.sv]
`timescale 1ns / 1ps
// Altitude, heading and speed hold: setpoint ramping and attitude target generation.
//
// Input channel (in_*): one item per control tick with the time step, measured
// airspeed, altitude and heading, and a restart flag that reloads all three
// setpoints from the start registers before the tick is applied.
// Result channel (out_*): one item per input item, in order: throttle, pitch
// target, bank target and the rate-damping enable.
// Configuration (cfg_*): write-only register file, written while no item is
// in flight; start values take effect at the next restart item.
//
// Pipeline: an accepted item passes through the input register, step multipliers,
// setpoint update, error forming, rounding numerators and reciprocal multipliers
// into the output register before its result shows on out_valid.
// Throughput: one item per cycle unless stalled, set by the setpoint update loop.
// Each stage holds one item; when out_stall is high the empty stages keep
// filling, and in_stall rises only once all six stages hold items.
// Reset (synchronous, rst_n low): configuration returns to its defaults, the
// setpoints load from the default start values and the pipeline empties.
module altitude_heading_speed_hold_unit #(
  parameter int SETPOINT_FRACTION_BITS = ahsh_pkg::SETPOINT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_time_step,
  input  logic [23:0]                     in_airspeed,
  input  logic [23:0]                     in_altitude_now,
  input  logic [15:0]                     in_heading_now,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_throttle,
  output logic signed [11:0]              out_pitch_target,
  output logic signed [14:0]              out_bank_target,
  output logic                            out_damping_on,
  input  logic                            cfg_wr_en,
  input  logic [ahsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ahsh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ahsh_pkg::*;

  localparam int SPW = 24 + SETPOINT_FRACTION_BITS;
  localparam int HW  = 16 + SETPOINT_FRACTION_BITS;

  cfg_t           cfg;
  logic           sp_valid, sp_ready;
  logic [23:0]    sp_airspeed, sp_altitude_now;
  logic [15:0]    sp_heading_now;
  logic [SPW-1:0] sp_alt, sp_spd;
  logic [HW-1:0]  sp_hdg;

  ahsh_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ahsh_setpoint #(
    .FRAC_BITS (SETPOINT_FRACTION_BITS)
  ) u_setpoint (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_time_step    (in_time_step),
    .in_airspeed     (in_airspeed),
    .in_altitude_now (in_altitude_now),
    .in_heading_now  (in_heading_now),
    .in_restart      (in_restart),
    .sp_valid        (sp_valid),
    .sp_ready        (sp_ready),
    .sp_airspeed     (sp_airspeed),
    .sp_altitude_now (sp_altitude_now),
    .sp_heading_now  (sp_heading_now),
    .sp_alt          (sp_alt),
    .sp_spd          (sp_spd),
    .sp_hdg          (sp_hdg)
  );

  ahsh_target #(
    .FRAC_BITS (SETPOINT_FRACTION_BITS)
  ) u_target (
    .clk              (clk),
    .rst_n            (rst_n),
    .mode_bits        (cfg.mode_bits),
    .sp_valid         (sp_valid),
    .sp_ready         (sp_ready),
    .sp_airspeed      (sp_airspeed),
    .sp_altitude_now  (sp_altitude_now),
    .sp_heading_now   (sp_heading_now),
    .sp_alt           (sp_alt),
    .sp_spd           (sp_spd),
    .sp_hdg           (sp_hdg),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_throttle     (out_throttle),
    .out_pitch_target (out_pitch_target),
    .out_bank_target  (out_bank_target),
    .out_damping_on   (out_damping_on)
  );

endmodule

[tb/hold_target_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the hold unit: tracks config and setpoints, predicts each command item, compares.
module hold_target_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [15:0]                     in_time_step,
  input  logic [23:0]                     in_airspeed,
  input  logic [23:0]                     in_altitude_now,
  input  logic [15:0]                     in_heading_now,
  input  logic                            in_restart,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [15:0]                     out_throttle,
  input  logic signed [11:0]              out_pitch_target,
  input  logic signed [14:0]              out_bank_target,
  input  logic                            out_damping_on,
  input  logic                            cfg_wr_en,
  input  logic [ahsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ahsh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              pending,
  output logic [23:0]                     alt_hint,
  output logic [23:0]                     spd_hint,
  output logic [15:0]                     hdg_hint
);
  import ahsh_pkg::*;

  localparam int     FB       = SETPOINT_FRAC_BITS_DEF;
  localparam longint HDG_MASK = (longint'(1) <<< (16 + FB)) - 1;
  localparam longint SP_TOP   = longint'(SP_RANGE_MAX) <<< FB;

  typedef struct {
    logic [15:0] throttle;
    logic [11:0] pitch;
    logic [14:0] bank;
    logic        damping;
  } hold_cmd_t;

  cfg_t      regs;
  longint    alt_sp;
  longint    hdg_sp;
  longint    spd_sp;
  hold_cmd_t cmd_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void load_setpoints();
    alt_sp = longint'(regs.altitude_start) <<< FB;
    hdg_sp = (longint'(regs.heading_start) <<< FB) & HDG_MASK;
    spd_sp = longint'(regs.speed_start) <<< FB;
  endfunction

  // rate * dt carries 16 fraction bits; rescale to FB with floor
  function automatic longint ramp(input longint rate, input logic [15:0] dt);
    longint p;
    p = rate * longint'(dt);
    if (FB >= 16) return p <<< ((FB >= 16) ? FB - 16 : 0);
    return p >>> ((FB < 16) ? 16 - FB : 0);
  endfunction

  function automatic longint clamp_range(input longint v);
    if (v < 0) return 0;
    if (v > SP_TOP) return SP_TOP;
    return v;
  endfunction

  // nearest, halves away from zero
  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (num * 2 + den) / (den * 2);
    return -((-num * 2 + den) / (den * 2));
  endfunction

  function automatic hold_cmd_t take_tick(input logic [15:0] dt, input logic [23:0] air,
                                          input logic [23:0] alt, input logic [15:0] hdg,
                                          input logic restart);
    hold_cmd_t r;
    longint    e, d, hd, h, thr, pitch, bank;
    if (restart) load_setpoints();
    hdg_sp = (hdg_sp + ramp(longint'($signed(regs.turn_rate)), dt)) & HDG_MASK;
    alt_sp = clamp_range(alt_sp + ramp(longint'($signed(regs.climb_rate)), dt));
    spd_sp = clamp_range(spd_sp + ramp(longint'($signed(regs.accel_rate)), dt));

    e = (longint'(air) <<< FB) - spd_sp;
    if (!regs.mode_bits[MODE_AUTO_THR] || e <= 0) thr = 65535;
    else if (e >= (longint'(THR_SPAN) <<< FB)) thr = 0;
    else thr = 65535 - (e * 65535 * 2 + (longint'(THR_SPAN) <<< FB))
                       / (longint'(2 * THR_SPAN) <<< FB);

    d = alt_sp - (longint'(alt) <<< FB);
    if (d > (longint'(PITCH_CLAMP) <<< FB)) d = longint'(PITCH_CLAMP) <<< FB;
    if (d < -(longint'(PITCH_CLAMP) <<< FB)) d = -(longint'(PITCH_CLAMP) <<< FB);
    pitch = round_div(d * 256, longint'(PITCH_HALF_DEN) <<< FB);

    // half-turn error lands on the negative side
    hd = ((longint'(hdg) <<< FB) - hdg_sp) & HDG_MASK;
    h  = hd[16+FB-1] ? hd - (longint'(1) <<< (16 + FB)) : hd;
    bank = round_div(h * 9, longint'(2) <<< FB);
    if (bank > BANK_LIMIT) bank = BANK_LIMIT;
    if (bank < -BANK_LIMIT) bank = -BANK_LIMIT;

    r.throttle = thr[15:0];
    r.pitch    = pitch[11:0];
    r.bank     = bank[14:0];
    r.damping  = regs.mode_bits[MODE_DAMPING];
    return r;
  endfunction

  always @(posedge clk) begin
    hold_cmd_t want;
    if (!rst_n) begin
      regs = CFG_RESET;
      load_setpoints();
      cmd_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ALT_START:  regs.altitude_start = cfg_wdata[23:0];
          REG_HDG_START:  regs.heading_start  = cfg_wdata[15:0];
          REG_SPD_START:  regs.speed_start    = cfg_wdata[23:0];
          REG_CLIMB_RATE: regs.climb_rate     = cfg_wdata[24:0];
          REG_TURN_RATE:  regs.turn_rate      = cfg_wdata[17:0];
          REG_ACCEL_RATE: regs.accel_rate     = cfg_wdata[24:0];
          REG_MODE_BITS:  regs.mode_bits      = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        cmd_q.push_back(take_tick(in_time_step, in_airspeed, in_altitude_now,
                                  in_heading_now, in_restart));
      if (out_valid && !out_stall) begin
        if (cmd_q.size() == 0) begin
          flag_mismatch("unexpected item, queue depth", 0, 0);
        end else begin
          want = cmd_q.pop_front();
          if (out_throttle !== want.throttle)
            flag_mismatch("throttle", out_throttle, want.throttle);
          if (out_pitch_target !== want.pitch)
            flag_mismatch("pitch_target", out_pitch_target, $signed(want.pitch));
          if (out_bank_target !== want.bank)
            flag_mismatch("bank_target", out_bank_target, $signed(want.bank));
          if (out_damping_on !== want.damping)
            flag_mismatch("damping_on", out_damping_on, want.damping);
        end
      end
    end
    pending  = cmd_q.size();
    alt_hint = 24'(alt_sp >>> FB);
    spd_hint = 24'(spd_sp >>> FB);
    hdg_hint = 16'(hdg_sp >>> FB);
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the hold unit testbench: clock, reset, register writes, tick stimulus and verdict.
module testbench;
  import ahsh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TICKS_PER_PHASE = 125;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_time_step;
  logic [23:0]           in_airspeed;
  logic [23:0]           in_altitude_now;
  logic [15:0]           in_heading_now;
  logic                  in_restart;
  logic                  out_valid;
  logic                  out_stall;
  logic [15:0]           out_throttle;
  logic signed [11:0]    out_pitch_target;
  logic signed [14:0]    out_bank_target;
  logic                  out_damping_on;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int          errors;
  int          pending;
  logic [23:0] alt_hint;
  logic [23:0] spd_hint;
  logic [15:0] hdg_hint;
  logic        calm;
  int          cycle_count;

  altitude_heading_speed_hold_unit dut (.*);

  hold_target_checker checker_0 (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[altitude_heading_speed_hold_unit] ERROR");
      $finish;
    end
  end

  // receiver: stall bursts, clean stretches, nothing once calm
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm) begin
        if ($urandom_range(0, 5) == 0) begin
          out_stall = 1'b1;
          n = $urandom_range(1, 18);
          repeat (n) @(negedge clk);
          out_stall = 1'b0;
        end else if ($urandom_range(0, 30) == 0) begin
          n = $urandom_range(20, 60);
          repeat (n) @(negedge clk);
        end
      end
    end
  end

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [15:0] dt, input logic [23:0] air, input logic [23:0] alt,
                           input logic [15:0] hdg, input logic rs);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_time_step    = dt;
    in_airspeed     = air;
    in_altitude_now = alt;
    in_heading_now  = hdg;
    in_restart      = rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [23:0] clip24(input longint v);
    if (v < 0) return 24'd0;
    if (v > 64'hFFFFFF) return 24'hFFFFFF;
    return v[23:0];
  endfunction

  // mostly near the current setpoints so the linear regions are reached
  task automatic random_tick();
    logic [15:0] dt;
    logic [23:0] air;
    logic [23:0] alt;
    logic [15:0] hdg;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) dt = 16'($urandom_range(0, 2000));
    else if (pick < 8) dt = 16'($urandom());
    else if (pick == 8) dt = 16'd0;
    else dt = 16'hFFFF;
    if ($urandom_range(0, 4) == 0) air = 24'($urandom());
    else air = clip24(longint'(spd_hint) + longint'($urandom_range(0, 120)) - 20);
    if ($urandom_range(0, 4) == 0) alt = 24'($urandom());
    else alt = clip24(longint'(alt_hint) + longint'($urandom_range(0, 18000)) - 9000);
    pick = $urandom_range(0, 9);
    if (pick < 2) hdg = 16'($urandom());
    else if (pick == 2) hdg = hdg_hint + 16'h8000;
    else hdg = 16'(int'(hdg_hint) + int'($urandom_range(0, 4000)) - 2000);
    send_tick(dt, air, alt, hdg, $urandom_range(0, 19) == 0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] signed_pick(input int span);
    int v;
    v = $urandom_range(0, span);
    if ($urandom_range(0, 1)) v = -v;
    return CFG_DATA_W'(v);
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] junk;
    rst_n           = 1'b0;
    calm            = 1'b0;
    in_valid        = 1'b0;
    in_time_step    = '0;
    in_airspeed     = '0;
    in_altitude_now = '0;
    in_heading_now  = '0;
    in_restart      = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default setpoints: altitude 16000, heading 16384, speed 3200, rates zero
    send_tick(16'd0,     24'd3200,     24'd16000,    16'd16384, 1'b0);
    send_tick(16'hFFFF,  24'd0,        24'd0,        16'd0,     1'b1);
    send_tick(16'hFFFF,  24'hFFFFFF,   24'hFFFFFF,   16'hFFFF,  1'b0);
    send_tick(16'd1,     24'd3201,     24'd24000,    16'd49152, 1'b0);  // half turn
    send_tick(16'd100,   24'd3208,     24'd8000,     16'd16385, 1'b0);  // rounding ties
    send_tick(16'd0,     24'd3224,     24'd16001,    16'd16383, 1'b0);
    send_tick(16'd0,     24'd3279,     24'd15999,    16'd18204, 1'b0);
    send_tick(16'd0,     24'd3280,     24'd23999,    16'd14563, 1'b0);  // throttle floor
    send_tick(16'd0,     24'd3199,     24'd8001,     16'd16384, 1'b0);
    send_tick(16'd32768, 24'd16000000, 24'd16000000, 16'd32768, 1'b0);
    send_tick(16'd0,     24'd3204,     24'd16562,    16'd16383, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      junk = CFG_DATA_W'($urandom());
      case (ph)
        1: begin
          apply_reg(REG_ALT_START,  {1'b0, 24'hFFFFFF});
          apply_reg(REG_HDG_START,  {9'h0, 16'hFFFF});
          apply_reg(REG_SPD_START,  {1'b0, 24'hFFFFFF});
          apply_reg(REG_CLIMB_RATE, 25'h0FFFFFF);
          apply_reg(REG_TURN_RATE,  {7'h0, 18'h1FFFF});
          apply_reg(REG_ACCEL_RATE, 25'h0FFFFFF);
        end
        2: begin
          apply_reg(REG_ALT_START,  '0);
          apply_reg(REG_HDG_START,  '0);
          apply_reg(REG_SPD_START,  '0);
          apply_reg(REG_CLIMB_RATE, 25'h1000000);
          apply_reg(REG_TURN_RATE,  {7'h7F, 18'h20000});
          apply_reg(REG_ACCEL_RATE, 25'h1000000);
        end
        default: begin
          // upper bits above a register's width are don't-care
          if ($urandom_range(0, 3) == 0) apply_reg(REG_ALT_START, junk);
          else apply_reg(REG_ALT_START, {junk[24], 24'($urandom_range(0, 16000000))});
          apply_reg(REG_HDG_START, CFG_DATA_W'($urandom()));
          if ($urandom_range(0, 3) == 0) apply_reg(REG_SPD_START, CFG_DATA_W'($urandom()));
          else apply_reg(REG_SPD_START, {junk[23], 24'($urandom_range(0, 16000000))});
          apply_reg(REG_CLIMB_RATE, signed_pick(40000));
          apply_reg(REG_TURN_RATE, CFG_DATA_W'($urandom()));
          apply_reg(REG_ACCEL_RATE, signed_pick(4000));
        end
      endcase
      apply_reg(REG_MODE_BITS, {junk[24:3], 3'(ph)});
      apply_reg(REG_SPARE, junk);
      cfg_wr_en = 1'b0;
      if (ph == 7) calm = 1'b1;
      for (int k = 0; k < TICKS_PER_PHASE; k++) random_tick();
    end

    settle();
    if (errors == 0) $display("[altitude_heading_speed_hold_unit] OK");
    else $display("[altitude_heading_speed_hold_unit] ERROR");
    $finish;
  end

endmodule
